// ===== rtl/core/euler_to_quaternion_macros.svh =====
// assertion helpers shared by the block
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// implication checked at every edge outside reset
`define E2Q_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("e2q check failed");

// implication whose consequent is checked in the following cycle
`define E2Q_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2q check failed");

`endif

// ===== rtl/core/e2q_pkg.sv =====
package e2q_pkg;

  localparam int AngW = 20;
  localparam int QW = 16;
  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int NSteps = (CordicSteps > AtanEntries) ? AtanEntries : CordicSteps;
  localparam int XW = 34;
  localparam int ZW = 33;
  localparam int PW = 64;
  localparam int MulLat = 3;
  localparam int Latency = 1 + NSteps + MulLat;

  localparam logic signed [ZW-1:0] AngPi = 33'sd843314857;
  localparam logic signed [ZW-1:0] AngTwoPi = 33'sd1686629713;
  localparam logic signed [ZW-1:0] AngHalfPi = 33'sd421657428;
  localparam logic signed [XW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [QW-1:0] QMax = 16'sd16384;

  typedef logic [4:0] step_idx_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic neg;
  } rot_t;

  typedef struct packed {
    rot_t roll;
    rot_t pitch;
    rot_t yaw;
  } rot3_t;

  function automatic logic signed [ZW-1:0] atan_q28(input step_idx_t i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 33'sd210828714;
      5'd1: r = 33'sd124459457;
      5'd2: r = 33'sd65760959;
      5'd3: r = 33'sd33381290;
      5'd4: r = 33'sd16755422;
      5'd5: r = 33'sd8385879;
      5'd6: r = 33'sd4193963;
      5'd7: r = 33'sd2097109;
      5'd8: r = 33'sd1048571;
      5'd9: r = 33'sd524287;
      default: r = (i < 5'd24) ? (ZW'(33'sd1) <<< (5'd28 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/e2q_if.sv =====
interface e2q_in_if import e2q_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [AngW-1:0] roll_angle;
  logic signed [AngW-1:0] pitch_angle;
  logic signed [AngW-1:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_out_if import e2q_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== rtl/core/e2q_reduce.sv =====
module e2q_reduce import e2q_pkg::*; (
  input  logic signed [AngW-1:0] angle,
  output rot_t                   rot
);
  logic signed [ZW-1:0] z0, z1, z2;

  function automatic logic signed [ZW-1:0] wrap(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    if (z > AngPi) r = z - AngTwoPi;
    else if (z < -AngPi) r = z + AngTwoPi;
    else r = z;
    return r;
  endfunction

  always_comb begin
    z0 = {{(ZW-AngW-12){angle[AngW-1]}}, angle, 12'd0};
    z1 = wrap(wrap(z0));
    rot.x = GainQ30;
    rot.y = '0;
    if (z1 > AngHalfPi) begin
      z2 = z1 - AngPi;
      rot.neg = 1'b1;
    end else if (z1 < -AngHalfPi) begin
      z2 = z1 + AngPi;
      rot.neg = 1'b1;
    end else begin
      z2 = z1;
      rot.neg = 1'b0;
    end
    rot.z = z2;
  end
endmodule

// ===== rtl/core/e2q_cell.sv =====
// one cordic rotation step for all three angles, registered
module e2q_cell import e2q_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  step_idx_t idx,
  input  rot3_t     din,
  output rot3_t     dout
);
  function automatic rot_t step(input rot_t a, input step_idx_t i);
    rot_t r;
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    dx = a.y >>> i;
    dy = a.x >>> i;
    at = atan_q28(i);
    r = a;
    if (!a.z[ZW-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - at;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + at;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dout.roll <= step(din.roll, idx);
      dout.pitch <= step(din.pitch, idx);
      dout.yaw <= step(din.yaw, idx);
    end
  end
endmodule

// ===== rtl/core/e2q_combine.sv =====
// three stage product tree: pairs, triples, sums with rounding and saturation
module e2q_combine import e2q_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  rot3_t           din,
  output logic signed [QW-1:0] qw,
  output logic signed [QW-1:0] qx,
  output logic signed [QW-1:0] qy,
  output logic signed [QW-1:0] qz
);
  logic signed [XW-1:0] sr, cr, sp, cp, sy, cy;
  logic signed [XW-1:0] cy_r, sy_r;
  logic signed [XW-1:0] a_cc, a_ss, a_sc, a_cs;
  logic signed [PW-1:0] t0, t1, t2, t3, t4, t5, t6, t7;

  function automatic logic signed [XW-1:0] rnd30(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
    logic signed [2*XW-1:0] p;
    p = (2*XW)'(a) * (2*XW)'(b) + (2*XW)'(64'sd536870912);
    return XW'(p >>> 30);
  endfunction

  function automatic logic signed [QW-1:0] q14(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b);
    logic signed [PW+1:0] s;
    logic signed [PW+1:0] v;
    s = (PW+2)'(a) + (PW+2)'(b) + (PW+2)'(66'sd35184372088832);
    v = s >>> 46;
    if (v > (PW+2)'(QMax)) return QMax;
    if (v < -(PW+2)'(QMax)) return -QMax;
    return QW'(v);
  endfunction

  always_comb begin
    cr = din.roll.neg ? -din.roll.x : din.roll.x;
    sr = din.roll.neg ? -din.roll.y : din.roll.y;
    cp = din.pitch.neg ? -din.pitch.x : din.pitch.x;
    sp = din.pitch.neg ? -din.pitch.y : din.pitch.y;
    cy = din.yaw.neg ? -din.yaw.x : din.yaw.x;
    sy = din.yaw.neg ? -din.yaw.y : din.yaw.y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cc <= rnd30(cr, cp);
      a_ss <= rnd30(sr, sp);
      a_sc <= rnd30(sr, cp);
      a_cs <= rnd30(cr, sp);
      cy_r <= cy;
      sy_r <= sy;
      t0 <= PW'(a_cc) * PW'(cy_r);
      t1 <= PW'(a_ss) * PW'(sy_r);
      t2 <= PW'(a_sc) * PW'(cy_r);
      t3 <= PW'(a_cs) * PW'(sy_r);
      t4 <= PW'(a_cs) * PW'(cy_r);
      t5 <= PW'(a_sc) * PW'(sy_r);
      t6 <= PW'(a_cc) * PW'(sy_r);
      t7 <= PW'(a_ss) * PW'(cy_r);
      qw <= q14(t0, t1);
      qx <= q14(t2, -t3);
      qy <= q14(t4, t5);
      qz <= q14(t6, -t7);
    end
  end
endmodule

// ===== rtl/core/euler_to_quaternion.sv =====
// euler_to_quaternion: roll, pitch, yaw (signed Q4.15 rad) in on the sink
// channel, unit quaternion w, x, y, z (signed Q1.14, saturated) out.
// each half angle is wrapped to +-pi, folded to +-pi/2, then run through a
// chain of cordic cells, one rotation step per cell, all three angles side
// by side. a three stage product tree forms the four parts.
// input to output beat: the reduce register, each cordic cell, the product tree.
// throughput: one beat per cycle; the whole pipe advances in lockstep.
// when the receiver stalls with a result waiting, the pipe freezes and
// ready drops; while the output register is empty or draining, input is
// taken every cycle.
// reset clears the valid bits of the pipe; data registers are not reset.
// the block keeps no state between beats.
`include "euler_to_quaternion_macros.svh"
module euler_to_quaternion import e2q_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  e2q_in_if.sink     in_ch,
  e2q_out_if.source  out_ch
);
  rot3_t red_r;
  rot3_t chain [NSteps+1];
  rot_t  rr, rp, ry;
  logic [Latency-1:0] vld;
  logic adv;

  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld[Latency-1];

  e2q_reduce u_red_r (.angle(in_ch.roll_angle), .rot(rr));
  e2q_reduce u_red_p (.angle(in_ch.pitch_angle), .rot(rp));
  e2q_reduce u_red_y (.angle(in_ch.yaw_angle), .rot(ry));

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r <= '{roll: rr, pitch: rp, yaw: ry};
    end
  end

  assign chain[0] = red_r;

  for (genvar g = 0; g < NSteps; g++) begin : g_cell
    e2q_cell u_cell (
      .clk(clk), .en(adv), .idx(step_idx_t'(g)), .din(chain[g]), .dout(chain[g+1])
    );
  end

  e2q_combine u_comb (
    .clk(clk), .en(adv), .din(chain[NSteps]),
    .qw(out_ch.quat_w), .qx(out_ch.quat_x), .qy(out_ch.quat_y), .qz(out_ch.quat_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Latency-2:0], in_ch.valid};
    end
  end

  `E2Q_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.quat_w))
  `E2Q_ASSERT_IMP(a_rdy, !in_ch.ready, out_ch.valid)
  `E2Q_ASSERT_IMP(a_range, out_ch.valid, out_ch.quat_w <= QMax && out_ch.quat_w >= -QMax)
endmodule

// ===== tb/sv/e2q_tb_pkg.sv =====
`timescale 1ns / 1ps
package e2q_tb_pkg;

  typedef struct packed {
    logic signed [19:0] roll;
    logic signed [19:0] pitch;
    logic signed [19:0] yaw;
  } euler_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

endpackage

// ===== tb/sv/euler_to_quaternion_tb.sv =====
`timescale 1ns / 1ps
module euler_to_quaternion_tb;
  import e2q_pkg::*;
  import e2q_tb_pkg::*;

  localparam longint HalfPi = 421657428;
  localparam longint FullPi = 843314857;
  localparam longint TwoPi = 1686629713;
  localparam longint CordicGain = 652032874;
  localparam int NumRandom = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  e2q_in_if in_ch ();
  e2q_out_if out_ch ();

  euler_to_quaternion dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  euler_t pending_angles[$];
  quat_t expected_quats[$];
  int errors = 0;
  int beats_out = 0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  longint atan_tab[24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963, 2097109,
    1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  // floor shift, matches >>> on a signed longint
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void half_angle_sincos(logic signed [19:0] ang,
                                            output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    int steps;
    z = longint'(ang) * 4096;
    x = CordicGain;
    y = 0;
    flip = 1'b0;
    steps = (CordicSteps > 24) ? 24 : CordicSteps;
    repeat (2) begin
      if (z > FullPi) z -= TwoPi;
      else if (z < -FullPi) z += TwoPi;
    end
    if (z > HalfPi) begin
      z -= FullPi;
      flip = 1'b1;
    end else if (z < -HalfPi) begin
      z += FullPi;
      flip = 1'b1;
    end
    for (int i = 0; i < steps; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint triple_product(longint a, longint b, longint c);
    return floor_shift(a * b + (longint'(1) << 29), 30) * c;
  endfunction

  function automatic logic signed [15:0] round_sat_q14(longint v);
    longint r;
    r = floor_shift(v + (longint'(1) << 45), 46);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  function automatic quat_t euler_to_quat(euler_t a);
    longint sr, cr, sp, cp, sy, cy;
    quat_t q;
    half_angle_sincos(a.roll, sr, cr);
    half_angle_sincos(a.pitch, sp, cp);
    half_angle_sincos(a.yaw, sy, cy);
    q.w = round_sat_q14(triple_product(cr, cp, cy) + triple_product(sr, sp, sy));
    q.x = round_sat_q14(triple_product(sr, cp, cy) - triple_product(cr, sp, sy));
    q.y = round_sat_q14(triple_product(cr, sp, cy) + triple_product(sr, cp, sy));
    q.z = round_sat_q14(triple_product(cr, cp, sy) - triple_product(sr, sp, cy));
    return q;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // random angle: mostly uniform, some near the wrap and fold points
  function automatic logic signed [19:0] pick_angle();
    int r;
    logic signed [19:0] base;
    r = $urandom_range(0, 9);
    if (r < 6) return 20'($urandom);
    case ($urandom_range(0, 4))
      0: base = 20'sd102944;   // pi in Q4.15 (half is pi/2)
      1: base = 20'sd205887;   // 2 pi (half is pi)
      2: base = 20'sd411775;   // 4 pi
      3: base = 20'sd524287;
      default: base = 20'sd0;
    endcase
    base = base + 20'($urandom_range(0, 8)) - 20'sd4;
    return ($urandom_range(0, 1) != 0) ? -base : base;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.roll_angle <= '0;
      in_ch.pitch_angle <= '0;
      in_ch.yaw_angle <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_quats.push_back(euler_to_quat(
          '{in_ch.roll_angle, in_ch.pitch_angle, in_ch.yaw_angle}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0 || hold_sender || pending_angles.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          euler_t a;
          a = pending_angles.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.roll_angle <= a.roll;
          in_ch.pitch_angle <= a.pitch;
          in_ch.yaw_angle <= a.yaw;
          send_gap <= pick_gap();
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_out <= beats_out + 1;
        if (expected_quats.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected beat w=%0d x=%0d y=%0d z=%0d", $time,
                   out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z);
        end else begin
          quat_t e;
          e = expected_quats.pop_front();
          if (out_ch.quat_w !== e.w || out_ch.quat_x !== e.x ||
              out_ch.quat_y !== e.y || out_ch.quat_z !== e.z) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d actual w=%0d x=%0d y=%0d z=%0d",
                     $time, e.w, e.x, e.y, e.z,
                     out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z);
          end
        end
      end
      if (recv_gap > 0) begin
        out_ch.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (!stim_done) recv_gap <= pick_gap();
      end
    end
  end

  initial begin
    logic signed [19:0] edge_vals[8];
    edge_vals = '{20'sh80000, 20'sh7FFFF, 20'sd0, 20'sd102944, -20'sd102944,
                  20'sd205887, -20'sd205887, 20'sd411775};
    // directed: field extremes, wrap and fold boundaries
    for (int i = 0; i < 8; i++)
      pending_angles.push_back('{edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]});
    pending_angles.push_back('{20'sh80000, 20'sh80000, 20'sh80000});
    pending_angles.push_back('{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF});
    pending_angles.push_back('{20'sh55555, 20'sh2AAAA, 20'shAAAAA});
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // sample at the falling edge so every update of the rising edge has settled
    do @(negedge clk); while (pending_angles.size() != 0 || in_ch.valid);
    hold_sender = 1'b1;
    do @(negedge clk); while (expected_quats.size() != 0 || in_ch.valid);
    hold_sender = 1'b0;
    for (int n = 0; n < NumRandom; n++)
      pending_angles.push_back('{pick_angle(), pick_angle(), pick_angle()});
    do @(negedge clk); while (pending_angles.size() != 0 || in_ch.valid);
    stim_done = 1'b1;
    do @(negedge clk); while (expected_quats.size() != 0);
    repeat (Latency + 10) @(posedge clk);
    $display("ran %0d quaternion beats over %0d directed and %0d random angle sets",
             beats_out, 11, NumRandom);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("** euler_to_quaternion: PASSED **");
    end else begin
      $display("** euler_to_quaternion: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d beats outstanding", expected_quats.size());
    $display("** euler_to_quaternion: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/e2q_pkg.sv
rtl/core/e2q_if.sv
rtl/core/e2q_reduce.sv
rtl/core/e2q_cell.sv
rtl/core/e2q_combine.sv
rtl/core/euler_to_quaternion.sv
tb/sv/e2q_tb_pkg.sv
tb/sv/euler_to_quaternion_tb.sv
